[rtl/moetk_pkg.sv]
// Shared types, constants and exponential tables for the top-k softmax router.
// Used by the front end, back end and top level; depends on nothing else.
`default_nettype none
package moetk_pkg;

    localparam int SCORE_WIDTH      = 16;
    localparam int DEF_MAX_SELECT   = 8;
    localparam int DEF_MAX_EXPERTS  = 64;
    localparam int SEL_W            = 4;
    localparam int NEXP_W           = 7;
    localparam int TOK_W            = 16;
    localparam int OUT_ID_W         = 6;
    localparam int GATE_W           = 16;
    localparam int EXP_W            = 17;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_COUNT = 1'b1;

    localparam logic [SEL_W-1:0]  SEL_RESET  = 4'd2;
    localparam logic [NEXP_W-1:0] NEXP_RESET = 7'd8;

    typedef struct packed {
        logic signed [SCORE_WIDTH-1:0] score;
        logic                          sequence_end;
    } t_item;

    typedef struct packed {
        logic [TOK_W-1:0]    token_index;
        logic [OUT_ID_W-1:0] chosen_expert;
        logic [GATE_W-1:0]   gate_weight;
        logic                last;
    } t_result;

    // exp(-a) for whole steps of the score difference, Q1.16.
    function automatic logic [EXP_W-1:0] int_exp(input logic [3:0] a);
        logic [EXP_W-1:0] v;
        case (a)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-b/16) for sixteenth steps, Q1.16.
    function automatic logic [EXP_W-1:0] frac_exp(input logic [3:0] b);
        logic [EXP_W-1:0] v;
        case (b)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/moetk_fifo.sv]
// Short register queue that carries finished token records from front to back.
// Depends on nothing but its parameters.
`default_nettype none
module moetk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

[rtl/moetk_front.sv]
// Front end: configuration registers, sorted top-k list and token counting.
// Depends on moetk_pkg; hands each finished token to the record queue.
`default_nettype none
module moetk_front
    import moetk_pkg::*;
#(
    parameter int MAX_SELECT  = DEF_MAX_SELECT,
    parameter int MAX_EXPERTS = DEF_MAX_EXPERTS,
    parameter int REC_W       = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire t_item                 i_item,
    output logic                       o_rec_wr,
    output logic [REC_W-1:0]           o_rec
);
    localparam int ID_W  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int CNT_W = $clog2(MAX_SELECT + 1);
    localparam int ENT_W = SCORE_WIDTH + ID_W;

    logic [SEL_W-1:0]              r_sel;
    logic [NEXP_W-1:0]             r_nexp;
    logic signed [SCORE_WIDTH-1:0] r_score [MAX_SELECT];
    logic [ID_W-1:0]               r_id    [MAX_SELECT];
    logic [CNT_W-1:0]              r_filled;
    logic [ID_W-1:0]               r_ecnt;
    logic [TOK_W-1:0]              r_tok;

    logic signed [SCORE_WIDTH-1:0] n_score [MAX_SELECT];
    logic [ID_W-1:0]               n_id    [MAX_SELECT];
    logic [CNT_W-1:0]              n_filled;
    logic [MAX_SELECT-1:0]         ge;
    logic                          tok_end;

    // Effective counts, insertion point and the shifted list.
    always_comb begin
        int ne, k, f;
        ne = int'(r_nexp);
        if (ne < 1) ne = 1;
        if (ne > MAX_EXPERTS) ne = MAX_EXPERTS;
        k = int'(r_sel);
        if (k < 1) k = 1;
        if (k > MAX_SELECT) k = MAX_SELECT;
        if (k > ne) k = ne;
        f = int'(r_filled);
        if (f > k) f = k;
        for (int i = 0; i < MAX_SELECT; i++) begin
            ge[i] = (i < f) && (r_score[i] >= i_item.score);
        end
        if (ge[0]) begin
            n_score[0] = r_score[0];
            n_id[0]    = r_id[0];
        end else begin
            n_score[0] = i_item.score;
            n_id[0]    = r_ecnt;
        end
        for (int i = 1; i < MAX_SELECT; i++) begin
            if (ge[i]) begin
                n_score[i] = r_score[i];
                n_id[i]    = r_id[i];
            end else if (ge[i-1]) begin
                n_score[i] = i_item.score;
                n_id[i]    = r_ecnt;
            end else begin
                n_score[i] = r_score[i-1];
                n_id[i]    = r_id[i-1];
            end
        end
        n_filled = CNT_W'((f < k) ? f + 1 : f);
        tok_end  = (int'(r_ecnt) + 1 >= ne);
    end

    // Token record for the back end.
    always_comb begin
        for (int i = 0; i < MAX_SELECT; i++) begin
            o_rec[i*ENT_W +: ENT_W] = {n_id[i], n_score[i]};
        end
        o_rec[MAX_SELECT*ENT_W +: CNT_W]         = n_filled;
        o_rec[MAX_SELECT*ENT_W + CNT_W +: TOK_W] = r_tok;
    end
    assign o_rec_wr = i_accept && tok_end;

    // The list itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < MAX_SELECT; i++) begin
                r_score[i] <= n_score[i];
                r_id[i]    <= n_id[i];
            end
        end
    end

    // Configuration and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= SEL_RESET;
            r_nexp   <= NEXP_RESET;
            r_filled <= '0;
            r_ecnt   <= '0;
            r_tok    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SELECT_COUNT: r_sel  <= i_cfg_data[SEL_W-1:0];
                    CFG_EXPERT_COUNT: r_nexp <= i_cfg_data[NEXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                if (tok_end) begin
                    r_filled <= '0;
                    r_ecnt   <= '0;
                    r_tok    <= i_item.sequence_end ? '0 : r_tok + TOK_W'(1);
                end else begin
                    r_filled <= n_filled;
                    r_ecnt   <= r_ecnt + ID_W'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/moetk_back.sv]
// Back end: exponentials, their sum and one long division per selected expert.
// Depends on moetk_pkg; reads token records from the queue, fills the result register.
`default_nettype none
module moetk_back
    import moetk_pkg::*;
#(
    parameter int MAX_SELECT  = DEF_MAX_SELECT,
    parameter int MAX_EXPERTS = DEF_MAX_EXPERTS,
    parameter int REC_W       = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [REC_W-1:0] i_rec,
    input  wire logic             i_rec_empty,
    output logic                  o_rec_rd,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output t_result               o_result
);
    localparam int ID_W   = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SELECT + 1);
    localparam int IDX_W  = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
    localparam int ENT_W  = SCORE_WIDTH + ID_W;
    localparam int SUM_W  = EXP_W + $clog2(MAX_SELECT + 1);
    localparam int NUM_W  = EXP_W + GATE_W;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int PROD_W = 2 * EXP_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_ACC   = 6'b000100,
        S_DINIT = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                        r_state;
    logic [IDX_W-1:0]              r_i;
    logic [PROD_W-1:0]             r_prod;
    logic [EXP_W-1:0]              r_ex [MAX_SELECT];
    logic [SUM_W-1:0]              r_sum;
    logic [NUM_W-1:0]              r_num;
    logic [SUM_W-1:0]              r_rem;
    logic [STEP_W-1:0]             r_step;
    logic                          r_ovalid;
    t_result                       r_out;

    logic signed [SCORE_WIDTH-1:0] s_head, s_cur;
    logic [ID_W-1:0]               id_cur;
    logic [CNT_W-1:0]              cnt;
    logic [TOK_W-1:0]              tok;
    logic signed [SCORE_WIDTH:0]   diff;
    logic                          far;
    logic [EXP_W-1:0]              e_new;
    logic [SUM_W:0]                rem_sh;
    logic                          qbit;
    logic                          is_last;
    logic                          slot_free;
    logic [GATE_W-1:0]             gate;

    // Fields of the current record.
    assign s_head  = i_rec[0 +: SCORE_WIDTH];
    assign s_cur   = i_rec[32'(r_i) * ENT_W +: SCORE_WIDTH];
    assign id_cur  = i_rec[32'(r_i) * ENT_W + SCORE_WIDTH +: ID_W];
    assign cnt     = i_rec[MAX_SELECT*ENT_W +: CNT_W];
    assign tok     = i_rec[MAX_SELECT*ENT_W + CNT_W +: TOK_W];
    assign is_last = (CNT_W'(r_i) + CNT_W'(1) == cnt);

    // Distance below the best score; exp uses its sixteenths, zero from sixteen whole steps on.
    assign diff  = {s_head[SCORE_WIDTH-1], s_head} - {s_cur[SCORE_WIDTH-1], s_cur};
    assign far   = |diff[SCORE_WIDTH:12];
    assign e_new = EXP_W'((r_prod + PROD_W'(32768)) >> 16);

    // One restoring division step.
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_sum});

    assign gate      = (|r_num[NUM_W-1:GATE_W]) ? {GATE_W{1'b1}} : r_num[GATE_W-1:0];
    assign slot_free = !r_ovalid || i_pop;
    assign o_rec_rd  = (r_state == S_OUT) && slot_free && is_last;
    assign o_empty   = !r_ovalid;
    assign o_result  = r_out;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sum <= '0;
            end
            S_MUL: begin
                r_prod <= far ? '0 :
                          PROD_W'(int_exp(diff[11:8])) * PROD_W'(frac_exp(diff[7:4]));
            end
            S_ACC: begin
                r_ex[r_i] <= e_new;
                r_sum     <= r_sum + SUM_W'(e_new);
            end
            S_DINIT: begin
                r_num  <= {r_ex[r_i], {GATE_W{1'b0}}} + NUM_W'(r_sum >> 1);
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= qbit ? SUM_W'(rem_sh - {1'b0, r_sum}) : rem_sh[SUM_W-1:0];
                r_num  <= {r_num[NUM_W-2:0], qbit};
                r_step <= r_step + STEP_W'(1);
            end
            default: ;
        endcase
        if (r_state == S_OUT && slot_free) begin
            r_out.token_index   <= tok;
            r_out.chosen_expert <= OUT_ID_W'(id_cur);
            r_out.gate_weight   <= gate;
            r_out.last          <= is_last;
        end
    end

    // Sequencer and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // A new result fills the slot; a pop alone empties it.
            if (r_state == S_OUT && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    if (!i_rec_empty) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (is_last) begin
                        r_i     <= '0;
                        r_state <= S_DINIT;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_DINIT: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_DINIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/moe_topk_softmax_gating_core.sv]
// Top-k softmax router for mixture-of-experts scores: top level.
// Depends on moetk_pkg, moetk_front, moetk_fifo and moetk_back.
//
// Usage: scores enter on the item queue port (push/full), one per expert, expert
// ids counting up from zero for each token. select_count and expert_count are set
// through the write port (index 0 and 1). After a token's last score the block
// offers one result per selected expert on the result queue port (empty/pop),
// best score first, with the softmax weight over the selected scores in Q0.16.
// Flow: the front takes one score per cycle while the record queue has
// room. Per token the back end forms the exponentials one selected expert at
// a time, then runs the bit-serial divider once per result; the divider
// dominates the back end's work. A token's first result follows the
// exponentials of all its selected experts and its first division. A
// two-entry record queue lets the front collect the next token meanwhile;
// it shows full while both entries wait.
// Reset returns the registers to select_count 2 and expert_count 8 and clears
// all counters and queues. When the receiver stalls, the result register holds
// and the back end waits; the front keeps taking scores until the queue fills.
`default_nettype none
module moe_topk_softmax_gating_core
    import moetk_pkg::*;
#(
    parameter int MAX_SELECT  = DEF_MAX_SELECT,
    parameter int MAX_EXPERTS = DEF_MAX_EXPERTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire t_item                 i_item,
    output logic                       empty,
    input  wire logic                  pop,
    output t_result                    o_result
);
    localparam int ID_W  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int CNT_W = $clog2(MAX_SELECT + 1);
    localparam int REC_W = MAX_SELECT * (SCORE_WIDTH + ID_W) + CNT_W + TOK_W;

    logic             rec_wr, rec_rd, rec_empty;
    logic [REC_W-1:0] rec_in, rec_out;

    // Front end: list upkeep on every accepted request.
    moetk_front #(
        .MAX_SELECT (MAX_SELECT),
        .MAX_EXPERTS(MAX_EXPERTS),
        .REC_W      (REC_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_accept  (push && !full),
        .i_item    (i_item),
        .o_rec_wr  (rec_wr),
        .o_rec     (rec_in)
    );

    // Finished tokens wait here for the back end.
    moetk_fifo #(
        .WIDTH(REC_W),
        .DEPTH(2)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (rec_wr),
        .i_wdata(rec_in),
        .o_full (full),
        .i_rd   (rec_rd),
        .o_rdata(rec_out),
        .o_empty(rec_empty)
    );

    // Back end: weights and result register.
    moetk_back #(
        .MAX_SELECT (MAX_SELECT),
        .MAX_EXPERTS(MAX_EXPERTS),
        .REC_W      (REC_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (rec_out),
        .i_rec_empty(rec_empty),
        .o_rec_rd   (rec_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );
endmodule
`default_nettype wire

[tb/sv/tb_gating_checker.sv]
// Checker for the top-k softmax router: watches accepted score requests,
// predicts the gating results and compares them with the result queue.
// Depends on moetk_pkg.
`timescale 1ns / 1ps
module tb_gating_checker
    import moetk_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire logic                  i_full,
    input  wire t_item                 i_item,
    input  wire logic                  i_empty,
    input  wire logic                  i_pop,
    input  wire t_result               i_result,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int KMAX = 8;
    localparam int NMAX = 64;

    // Predictor state.
    logic signed [SCORE_WIDTH-1:0] top_scores [KMAX];
    logic [OUT_ID_W-1:0]           top_ids [KMAX];
    int unsigned                   kept;
    int unsigned                   expert_pos;
    logic [TOK_W-1:0]              token_pos;
    logic [SEL_W-1:0]              sel_reg;
    logic [NEXP_W-1:0]             nexp_reg;
    t_result                       gate_queue [$];

    int fails;
    assign o_fail_count = fails;
    assign o_pending    = gate_queue.size();

    // Table exponential of a nonnegative Q8.8 distance, Q1.16.
    function automatic longint unsigned exp_of_gap(input longint gap);
        longint unsigned j;
        longint unsigned ta;
        longint unsigned tb;
        j = longint'(gap) >>> 4;
        if (j >= 256) return 0;
        ta = int_exp(j[7:4]);
        tb = frac_exp(j[3:0]);
        return (ta * tb + 32768) >> 16;
    endfunction

    // Insert one score and emit the token's results when it is complete.
    task automatic take_score(input t_item it);
        int unsigned     ne;
        int unsigned     k;
        int unsigned     pos;
        int unsigned     top;
        longint unsigned ex [KMAX];
        longint unsigned sum;
        longint unsigned w;
        t_result         r;
        ne = (nexp_reg < 1) ? 1 : (nexp_reg > NMAX) ? NMAX : nexp_reg;
        k  = (sel_reg < 1) ? 1 : (sel_reg > KMAX) ? KMAX : sel_reg;
        if (k > ne) k = ne;
        if (kept > k) kept = k;
        pos = 0;
        while (pos < kept && top_scores[pos] >= it.score) pos++;
        if (pos < k) begin
            top = (kept < k) ? kept : k - 1;
            for (int i = top; i > pos; i--) begin
                top_scores[i] = top_scores[i-1];
                top_ids[i]    = top_ids[i-1];
            end
            top_scores[pos] = it.score;
            top_ids[pos]    = expert_pos[OUT_ID_W-1:0];
            if (kept < k) kept++;
        end
        if (expert_pos + 1 < ne) begin
            expert_pos++;
            return;
        end
        sum = 0;
        for (int i = 0; i < kept; i++) begin
            ex[i] = exp_of_gap(longint'(top_scores[0]) - longint'(top_scores[i]));
            sum += ex[i];
        end
        for (int i = 0; i < kept; i++) begin
            w = (ex[i] * 65536 + sum / 2) / sum;
            if (w > 65535) w = 65535;
            r.token_index   = token_pos;
            r.chosen_expert = top_ids[i];
            r.gate_weight   = w[GATE_W-1:0];
            r.last          = (i + 1 == kept);
            gate_queue.insert(gate_queue.size(), r);
        end
        kept = 0;
        expert_pos = 0;
        token_pos = it.sequence_end ? '0 : token_pos + 1'b1;
    endtask

    // Track requests, configuration writes and results at each rising edge.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            kept = 0;
            expert_pos = 0;
            token_pos = '0;
            sel_reg = SEL_RESET;
            nexp_reg = NEXP_RESET;
            gate_queue.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SELECT_COUNT) sel_reg = i_cfg_data[SEL_W-1:0];
                else nexp_reg = i_cfg_data[NEXP_W-1:0];
            end
            if (i_pop && !i_empty) begin
                if (gate_queue.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result %p", $time, i_result);
                end else begin
                    exp_r = gate_queue.pop_front();
                    if (exp_r !== i_result) begin
                        fails++;
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_r, i_result);
                    end
                end
            end
            if (i_push && !i_full) take_score(i_item);
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the router testbench: clock, reset, request stimulus, result draining.
// Depends on moetk_pkg, the router core and tb_gating_checker.
`timescale 1ns / 1ps
module tb_top;
    import moetk_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_SELECT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    t_item                 item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               result;
    int                    fail_count;
    int                    pending;
    bit                    long_hold = 1'b0;
    bit                    rx_bursty = 1'b1;
    longint                cycles = 0;
    int                    sel_now = 2;
    int                    nexp_now = 8;

    always #6 clk = ~clk;

    moe_topk_softmax_gating_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .push(push), .full(full), .i_item(item),
        .empty(empty), .pop(pop), .o_result(result)
    );

    tb_gating_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_push(push), .i_full(full), .i_item(item),
        .i_empty(empty), .i_pop(pop), .i_result(result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Run limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random pops, plus a long hold-off when requested.
    initial begin
        int g;
        forever begin
            @(negedge clk);
            if (long_hold) begin
                pop <= 1'b0;
                repeat (1500) @(negedge clk);
                long_hold = 1'b0;
            end
            g = rx_bursty ? gap_len() : 0;
            if (g > 0) begin
                pop <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one score request and hold it until accepted.
    // Driven at the falling edge, so back-to-back requests may update push twice there.
    task automatic send_score(input logic signed [SCORE_WIDTH-1:0] s, input bit seq_end,
                              input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            push = 1'b0;
            repeat (g) @(negedge clk);
        end
        push = 1'b1;
        item = '{score: s, sequence_end: seq_end};
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        push = 1'b0;
    endtask

    // Wait for every expected result, then allow the back end to settle.
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input int sel, input int nexp);
        drain();
        write_reg(CFG_SELECT_COUNT, sel);
        write_reg(CFG_EXPERT_COUNT, nexp);
        sel_now = sel;
        nexp_now = nexp;
    endtask

    // One token with random scores; mode picks wide range, ties or a narrow spread.
    task automatic send_token(input int mode, input bit seq_end, input bit gaps);
        int n;
        logic signed [SCORE_WIDTH-1:0] s;
        n = (nexp_now < 1) ? 1 : (nexp_now > 64 ? 64 : nexp_now);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: s = 16'($urandom);
                1: s = 16'($urandom_range(0, 3) * 256);
                default: s = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            endcase
            send_score(s, (i == n - 1) ? seq_end : bit'($urandom_range(0, 1)), gaps);
        end
    endtask

    int items_sent;
    int cfg_sel [6] = '{1, 8, 3, 15, 0, 5};
    int cfg_nexp [6] = '{1, 64, 5, 127, 0, 12};

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset config, extremes, ties, saturation, sequence end.
        send_score(16'sh7fff, 1'b0, 1'b0);
        send_score(-16'sh8000, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++) send_score(16'sh0000, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) send_score(16'sh0100, i == 7, 1'b0);
        for (int i = 0; i < 8; i++) send_score(16'(16'shffff - i * 16'sh1000), 1'b1, 1'b0);

        // Configuration written mid-token: list trimmed, token ended early.
        drain();
        write_reg(CFG_SELECT_COUNT, 8);
        send_score(16'sh0200, 1'b0, 1'b0);
        send_score(16'sh0100, 1'b0, 1'b0);
        send_score(16'sh0300, 1'b0, 1'b0);
        drain();
        write_reg(CFG_SELECT_COUNT, 1);
        write_reg(CFG_EXPERT_COUNT, 3);
        send_score(16'sh0050, 1'b1, 1'b0);
        sel_now = 1;
        nexp_now = 3;

        // Random part through several settings.
        items_sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            set_config(cfg_sel[ph], cfg_nexp[ph]);
            rx_bursty = (ph != 2);
            if (ph == 1) begin
                // Long receiver stall while the sender keeps pushing.
                long_hold = 1'b1;
            end
            while (items_sent < (ph + 1) * 70) begin
                send_token($urandom_range(0, 2), $urandom_range(0, 9) == 0,
                           ph != 3);
                items_sent += (nexp_now < 1) ? 1 : (nexp_now > 64 ? 64 : nexp_now);
                if ($urandom_range(0, 15) == 0) drain();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/moetk_pkg.sv
rtl/moetk_fifo.sv
rtl/moetk_front.sv
rtl/moetk_back.sv
rtl/moe_topk_softmax_gating_core.sv
tb/sv/tb_gating_checker.sv
tb/sv/tb_top.sv
